[hdl/windowed_xor_strobe_selector_macros.svh]
// Assertion macros for the windowed XOR strobe selector.
`ifndef WINDOWED_XOR_STROBE_SELECTOR_MACROS_SVH
`define WINDOWED_XOR_STROBE_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define WXSS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define WXSS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define WXSS_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons)
`define WXSS_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

[hdl/wxss_pkg.sv]
package wxss_pkg;

  localparam int VAL_W     = 64;
  localparam int HASH_W    = 64;
  localparam int OFF_W     = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int RQ_DEPTH  = 128;
  localparam int RQ_AW     = 7;
  localparam int RQ_LW     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_MAX   = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [HASH_W-1:0] hash;
  } ring_entry_t;

  typedef struct packed {
    logic [HASH_W-1:0] strobe_hash;
    logic [OFF_W-1:0]  offset;
  } result_t;

  typedef struct packed {
    logic anchor;
    logic cand;
    logic first;
  } score_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last_one;
  } rq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ANCHOR,
    S_SCAN,
    S_EMIT,
    S_POP,
    S_OUT
  } state_t;

endpackage

[hdl/wxss_ring.sv]
module wxss_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  wxss_pkg::ring_entry_t wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output wxss_pkg::ring_entry_t rd_data
);

  wxss_pkg::ring_entry_t mem [DEPTH];
  wxss_pkg::ring_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/wxss_score.sv]
module wxss_score #(
  parameter int AW = 6
) (
  input  logic                          clk,
  input  wxss_pkg::score_ctl_t          ctl,
  input  logic [AW-1:0]                 cand_off,
  input  logic                          pick_max,
  input  wxss_pkg::ring_entry_t         rd_data,
  output logic [wxss_pkg::HASH_W-1:0]   strobe_hash,
  output logic [AW-1:0]                 best_off
);

  logic [wxss_pkg::VAL_W-1:0]  anc_val_r;
  logic [wxss_pkg::HASH_W-1:0] anc_hash_r;
  logic [wxss_pkg::VAL_W-1:0]  best_score_r;
  logic [wxss_pkg::HASH_W-1:0] best_hash_r;
  logic [AW-1:0]               best_off_r;
  logic [wxss_pkg::VAL_W-1:0]  score;
  logic                        better;

  assign score  = anc_val_r ^ rd_data.value;
  assign better = pick_max ? (score > best_score_r) : (score < best_score_r);

  always_ff @(posedge clk) begin
    if (ctl.anchor) begin
      anc_val_r  <= rd_data.value;
      anc_hash_r <= rd_data.hash;
    end
    if (ctl.cand && (ctl.first || better)) begin
      best_score_r <= score;
      best_hash_r  <= rd_data.hash;
      best_off_r   <= cand_off;
    end
  end

  assign strobe_hash = {anc_hash_r[wxss_pkg::HASH_W-2:0], 1'b0} - best_hash_r;
  assign best_off    = best_off_r;

endmodule

[hdl/wxss_rq.sv]
module wxss_rq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wxss_pkg::result_t     push_data,
  input  logic                  rd_en,
  input  logic                  advance,
  output wxss_pkg::result_t     rd_data,
  output wxss_pkg::rq_status_t  status
);

  wxss_pkg::result_t               mem [wxss_pkg::RQ_DEPTH];
  wxss_pkg::result_t               rd_data_r;
  logic [wxss_pkg::RQ_AW-1:0]      head_r;
  logic [wxss_pkg::RQ_AW-1:0]      head_nxt;
  logic [wxss_pkg::RQ_LW-1:0]      len_r;
  logic [wxss_pkg::RQ_LW-1:0]      len_nxt;
  logic [wxss_pkg::RQ_AW-1:0]      wr_addr;
  logic                            push_ok;
  logic                            pop_ok;

  assign status.empty    = (len_r == '0);
  assign status.full     = (len_r == wxss_pkg::RQ_LW'(wxss_pkg::RQ_DEPTH));
  assign status.last_one = (len_r == wxss_pkg::RQ_LW'(1));

  assign push_ok = push && !status.full;
  assign pop_ok  = advance && !status.empty;
  assign wr_addr = head_r + len_r[wxss_pkg::RQ_AW-1:0];

  always_comb begin
    head_nxt = head_r;
    len_nxt  = len_r;
    if (pop_ok) begin
      head_nxt = head_r + wxss_pkg::RQ_AW'(1);
    end
    case ({push_ok, pop_ok})
      2'b10:   len_nxt = len_r + wxss_pkg::RQ_LW'(1);
      2'b01:   len_nxt = len_r - wxss_pkg::RQ_LW'(1);
      default: len_nxt = len_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      len_r  <= '0;
    end else begin
      head_r <= head_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_addr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/windowed_xor_strobe_selector.sv]
// Windowed XOR strobe selector.
// Input channel (in_valid/in_ready): one k-mer per transfer, its packed value,
// its hash and an end-of-sequence mark. Result channel (out_valid/out_ready):
// at most one strobe per input transfer, taken in order from an internal
// result queue; out_run_end is set when that queue is empty after the result.
// Configuration (cfg_wr_en/cfg_index/cfg_wdata): window_min, window_max and
// pick_max, to be written by the user only while the block is idle; the block leaves this unchecked.
// Each input is written into the window store, then every anchor whose window
// is complete is decided by one shared XOR/compare unit that reads one stored
// partner per cycle. Each anchor is scored against span candidate partners
// (at most window_max - window_min + 1), then its strobe joins the queue. After
// the anchors, an input reads the queue and loads one result into the output
// register if the queue holds any; the last item of a sequence flushes up to
// window_max - window_min anchors in one go (one when the two are equal).
// in_ready is high only when idle.
// A stalled receiver holds the result register; the block then finishes the
// next item up to its result and waits. Reset empties the window and the
// result queue and sets the registers to 1, 8 and 0; no clearing pass.
`include "windowed_xor_strobe_selector_macros.svh"

module windowed_xor_strobe_selector #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wxss_pkg::VAL_W-1:0]          in_kmer_value,
  input  logic [wxss_pkg::HASH_W-1:0]         in_kmer_hash,
  input  logic                                in_is_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wxss_pkg::HASH_W-1:0]         out_strobe_hash,
  output logic [wxss_pkg::OFF_W-1:0]          out_partner_offset,
  output logic                                out_run_end,
  input  logic                                cfg_wr_en,
  input  logic [wxss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wxss_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int CW     = $clog2(WINDOW_DEPTH + 1);
  localparam int LO_MAX = (WINDOW_DEPTH - 2 < 62) ? WINDOW_DEPTH - 2 : 62;
  localparam int HI_MAX = (WINDOW_DEPTH - 1 < 63) ? WINDOW_DEPTH - 1 : 63;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(WINDOW_DEPTH);

  wxss_pkg::state_t               state_r, state_nxt;
  logic [wxss_pkg::CFG_W-1:0]     cfg_min_r, cfg_max_r;
  logic                           cfg_pick_r;
  logic [AW-1:0]                  wr_slot_r, wr_slot_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           last_r;
  logic [AW-1:0]                  anc_r, top_r;
  logic [AW:0]                    iss_o_r;
  logic                           iss_first_r;
  logic                           pend_anchor_r, pend_vld_r, pend_first_r;
  logic [AW-1:0]                  pend_off_r;
  logic                           out_valid_r;
  logic [wxss_pkg::HASH_W-1:0]    out_hash_r;
  logic [wxss_pkg::OFF_W-1:0]     out_off_r;
  logic                           out_end_r;

  logic [wxss_pkg::CFG_W-1:0]     lo6, hi6;
  logic [AW-1:0]                  lo_c, hi_c, need_c, dist_c, anc_c, top_c;
  logic [AW:0]                    psum;
  logic [AW-1:0]                  part_addr;
  logic                           decide_c, issue_c, scan_done, out_free;

  logic                           accept, ring_re, push, rq_rd, out_load;
  logic [AW-1:0]                  ring_raddr;
  wxss_pkg::ring_entry_t          ring_wdata, ring_rdata;
  wxss_pkg::score_ctl_t           score_ctl;
  logic [wxss_pkg::HASH_W-1:0]    strobe_hash;
  logic [AW-1:0]                  best_off;
  wxss_pkg::result_t              push_data, rq_data;
  wxss_pkg::rq_status_t           rq_status;

  // effective window bounds
  always_comb begin
    lo6 = (cfg_min_r == '0) ? wxss_pkg::CFG_W'(1) : cfg_min_r;
    if (lo6 > wxss_pkg::CFG_W'(LO_MAX)) begin
      lo6 = wxss_pkg::CFG_W'(LO_MAX);
    end
    hi6 = (cfg_max_r > wxss_pkg::CFG_W'(HI_MAX)) ? wxss_pkg::CFG_W'(HI_MAX) : cfg_max_r;
    if (hi6 < lo6) begin
      hi6 = lo6;
    end
  end

  assign lo_c     = AW'(lo6);
  assign hi_c     = AW'(hi6);
  assign need_c   = (last_r || !(hi_c > lo_c)) ? lo_c + AW'(1) : hi_c;
  assign decide_c = (cnt_r >= CW'(need_c) + CW'(1));
  assign dist_c   = AW'(cnt_r - CW'(1));
  assign anc_c    = (wr_slot_r >= dist_c) ? wr_slot_r - dist_c
                                          : AW'({1'b0, wr_slot_r} + DEPTH_W - {1'b0, dist_c});
  assign top_c    = (hi_c < dist_c) ? hi_c : dist_c;

  assign psum      = {1'b0, anc_r} + iss_o_r;
  assign part_addr = (psum >= DEPTH_W) ? AW'(psum - DEPTH_W) : AW'(psum);
  assign issue_c   = (iss_o_r <= {1'b0, top_r});
  assign scan_done = !issue_c && !pend_vld_r && !pend_anchor_r;
  assign out_free  = !out_valid_r || out_ready;

  assign wr_slot_nxt = (wr_slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_slot_r + AW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wxss_pkg::S_IDLE:   if (in_valid) state_nxt = wxss_pkg::S_CHECK;
      wxss_pkg::S_CHECK:  state_nxt = decide_c ? wxss_pkg::S_ANCHOR : wxss_pkg::S_POP;
      wxss_pkg::S_ANCHOR: state_nxt = wxss_pkg::S_SCAN;
      wxss_pkg::S_SCAN:   if (scan_done) state_nxt = wxss_pkg::S_EMIT;
      wxss_pkg::S_EMIT:   state_nxt = wxss_pkg::S_CHECK;
      wxss_pkg::S_POP:    state_nxt = rq_status.empty ? wxss_pkg::S_IDLE : wxss_pkg::S_OUT;
      wxss_pkg::S_OUT:    if (out_free) state_nxt = wxss_pkg::S_IDLE;
      default:            state_nxt = wxss_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    ring_re    = 1'b0;
    ring_raddr = anc_r;
    push       = 1'b0;
    rq_rd      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      wxss_pkg::S_IDLE:   in_ready = 1'b1;
      wxss_pkg::S_ANCHOR: ring_re = 1'b1;
      wxss_pkg::S_SCAN: begin
        ring_re    = issue_c;
        ring_raddr = part_addr;
      end
      wxss_pkg::S_EMIT:   push = 1'b1;
      wxss_pkg::S_POP:    rq_rd = !rq_status.empty;
      wxss_pkg::S_OUT:    out_load = out_free;
      default:            in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (state_r == wxss_pkg::S_EMIT) begin
      cnt_nxt = cnt_r - CW'(1);
    end else if (state_r == wxss_pkg::S_CHECK && !decide_c && last_r) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= wxss_pkg::S_IDLE;
      cfg_min_r     <= wxss_pkg::CFG_W'(1);
      cfg_max_r     <= wxss_pkg::CFG_W'(8);
      cfg_pick_r    <= 1'b0;
      wr_slot_r     <= '0;
      cnt_r         <= '0;
      last_r        <= 1'b0;
      iss_o_r       <= '0;
      iss_first_r   <= 1'b0;
      pend_anchor_r <= 1'b0;
      pend_vld_r    <= 1'b0;
      pend_first_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          wxss_pkg::CFG_WINDOW_MIN: cfg_min_r  <= cfg_wdata;
          wxss_pkg::CFG_WINDOW_MAX: cfg_max_r  <= cfg_wdata;
          wxss_pkg::CFG_PICK_MAX:   cfg_pick_r <= cfg_wdata[0];
          default:                  cfg_pick_r <= cfg_pick_r;
        endcase
      end
      if (accept) begin
        wr_slot_r <= wr_slot_nxt;
        last_r    <= in_is_last;
      end
      if (state_r == wxss_pkg::S_CHECK) begin
        iss_o_r     <= {1'b0, lo_c};
        iss_first_r <= 1'b1;
      end else if (state_r == wxss_pkg::S_SCAN && issue_c) begin
        iss_o_r     <= iss_o_r + (AW + 1)'(1);
        iss_first_r <= 1'b0;
      end
      pend_anchor_r <= (state_r == wxss_pkg::S_ANCHOR);
      pend_vld_r    <= (state_r == wxss_pkg::S_SCAN) && issue_c;
      pend_first_r  <= iss_first_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == wxss_pkg::S_CHECK) begin
      anc_r <= anc_c;
      top_r <= top_c;
    end
    pend_off_r <= AW'(iss_o_r);
    if (out_load) begin
      out_hash_r <= rq_data.strobe_hash;
      out_off_r  <= rq_data.offset;
      out_end_r  <= rq_status.last_one;
    end
  end

  assign ring_wdata.value = in_kmer_value;
  assign ring_wdata.hash  = in_kmer_hash;

  wxss_ring #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_slot_nxt),
    .wr_data (ring_wdata),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  assign score_ctl.anchor = pend_anchor_r;
  assign score_ctl.cand   = pend_vld_r;
  assign score_ctl.first  = pend_first_r;

  wxss_score #(
    .AW (AW)
  ) u_score (
    .clk         (clk),
    .ctl         (score_ctl),
    .cand_off    (pend_off_r),
    .pick_max    (cfg_pick_r),
    .rd_data     (ring_rdata),
    .strobe_hash (strobe_hash),
    .best_off    (best_off)
  );

  assign push_data.strobe_hash = strobe_hash;
  assign push_data.offset      = wxss_pkg::OFF_W'(best_off);

  wxss_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .rd_en     (rq_rd),
    .advance   (out_load),
    .rd_data   (rq_data),
    .status    (rq_status)
  );

  assign out_valid          = out_valid_r;
  assign out_strobe_hash    = out_hash_r;
  assign out_partner_offset = out_off_r;
  assign out_run_end        = out_end_r;

  `WXSS_ASSERT_IMP(a_out_from_queue, clk, rst_n, $rose(out_valid_r), $past(state_r == wxss_pkg::S_OUT))
  `WXSS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(WINDOW_DEPTH))
  `WXSS_ASSERT_IMP(a_scan_bound, clk, rst_n, state_r == wxss_pkg::S_SCAN, iss_o_r <= {1'b0, top_r} + (AW + 1)'(1))
  `WXSS_ASSERT_IMP(a_offset_nonzero, clk, rst_n, out_valid_r, out_off_r != '0)
  `WXSS_ASSERT_NXT(a_accept_counts, clk, rst_n, in_valid && in_ready, cnt_r != '0)

endmodule

[tb/tb_windowed_xor_strobe_selector.sv]
module tb_windowed_xor_strobe_selector;

  localparam int RING = 64;
  localparam int BACKLOG_CAP = 128;
  localparam int IDLE_PCT = 17;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 80;
  localparam longint LIMIT = 3000000;
  localparam logic [wxss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [wxss_pkg::HASH_W-1:0] hash;
    logic [wxss_pkg::OFF_W-1:0]  off;
    logic                        run_end;
  } strobe_t;

  typedef struct {
    bit                             is_cfg;
    logic [wxss_pkg::CFG_IDX_W-1:0] idx;
    logic [wxss_pkg::CFG_W-1:0]     data;
    logic [wxss_pkg::VAL_W-1:0]     val;
    logic [wxss_pkg::HASH_W-1:0]    hash;
    bit                             last;
    bit                             typed;
    strobe_t                        want;
  } plan_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [wxss_pkg::VAL_W-1:0]     in_kmer_value = '0;
  logic [wxss_pkg::HASH_W-1:0]    in_kmer_hash = '0;
  logic                           in_is_last = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [wxss_pkg::HASH_W-1:0]    out_strobe_hash;
  logic [wxss_pkg::OFF_W-1:0]     out_partner_offset;
  logic                           out_run_end;
  logic                           cfg_wr_en = 1'b0;
  logic [wxss_pkg::CFG_IDX_W-1:0] cfg_index = wxss_pkg::CFG_WINDOW_MIN;
  logic [wxss_pkg::CFG_W-1:0]     cfg_wdata = '0;

  windowed_xor_strobe_selector #(.WINDOW_DEPTH(RING)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kmer_value      (in_kmer_value),
    .in_kmer_hash       (in_kmer_hash),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_strobe_hash    (out_strobe_hash),
    .out_partner_offset (out_partner_offset),
    .out_run_end        (out_run_end),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // window copy and settings
  logic [wxss_pkg::VAL_W-1:0]  win_val [RING];
  logic [wxss_pkg::HASH_W-1:0] win_hash [RING];
  int unsigned                 open_anchors = 0;
  int unsigned                 head_slot = 0;
  logic [wxss_pkg::CFG_W-1:0]  wmin_q = 6'd1;
  logic [wxss_pkg::CFG_W-1:0]  wmax_q = 6'd8;
  logic                        pick_q = 1'b0;

  strobe_t   strobe_backlog[$];
  strobe_t   strobes_due[$];
  plan_row_t plan[$];
  int        errors = 0;
  longint    cycles = 0;
  bit        calm = 1'b0;

  always #5 clk = ~clk;

  function automatic int unsigned near_off();
    int unsigned m;
    m = wmin_q;
    if (m < 1) m = 1;
    if (m > 62) m = 62;
    return m;
  endfunction

  function automatic int unsigned far_off(int unsigned lo);
    int unsigned m;
    m = wmax_q;
    if (m < lo) m = lo;
    return m;
  endfunction

  function automatic int unsigned ring_at(int unsigned back);
    return (head_slot + RING - back) % RING;
  endfunction

  // score partners of the anchor back items before the newest, queue the strobe
  function automatic void pick_partner(int unsigned back, int unsigned lo, int unsigned hi);
    int unsigned                a;
    int unsigned                top;
    int unsigned                best;
    logic [wxss_pkg::VAL_W-1:0] score;
    logic [wxss_pkg::VAL_W-1:0] s;
    strobe_t                    r;
    a = ring_at(back);
    top = (hi < back) ? hi : back;
    best = lo;
    score = win_val[a] ^ win_val[ring_at(back - lo)];
    for (int unsigned o = lo + 1; o <= top; o++) begin
      s = win_val[a] ^ win_val[ring_at(back - o)];
      if (pick_q ? (s > score) : (s < score)) begin
        score = s;
        best = o;
      end
    end
    r.hash = (win_hash[a] << 1) - win_hash[ring_at(back - best)];
    r.off = wxss_pkg::OFF_W'(best);
    r.run_end = 1'b0;
    if (strobe_backlog.size() < BACKLOG_CAP) strobe_backlog.insert(strobe_backlog.size(), r);
  endfunction

  function automatic bit take_kmer(logic [wxss_pkg::VAL_W-1:0] v,
                                   logic [wxss_pkg::HASH_W-1:0] h, bit last,
                                   output strobe_t r);
    int unsigned lo;
    int unsigned hi;
    int unsigned need;
    lo = near_off();
    hi = far_off(lo);
    need = last ? lo + 1 : (hi > lo ? hi : lo + 1);
    head_slot = (head_slot + 1) % RING;
    win_val[head_slot] = v;
    win_hash[head_slot] = h;
    open_anchors++;
    while (open_anchors >= 1 && open_anchors - 1 >= need) begin
      pick_partner(open_anchors - 1, lo, hi);
      open_anchors--;
    end
    if (last) open_anchors = 0;
    r = '0;
    if (strobe_backlog.size() == 0) return 1'b0;
    r = strobe_backlog.pop_front();
    r.run_end = (strobe_backlog.size() == 0);
    return 1'b1;
  endfunction

  function automatic void set_reg(logic [wxss_pkg::CFG_IDX_W-1:0] idx,
                                  logic [wxss_pkg::CFG_W-1:0] data);
    case (idx)
      wxss_pkg::CFG_WINDOW_MIN: wmin_q = data;
      wxss_pkg::CFG_WINDOW_MAX: wmax_q = data;
      wxss_pkg::CFG_PICK_MAX:   pick_q = data[0];
      default: ;
    endcase
  endfunction

  function automatic void plan_known(logic [wxss_pkg::VAL_W-1:0] v,
                                     logic [wxss_pkg::HASH_W-1:0] h, bit last, bit typed,
                                     logic [wxss_pkg::HASH_W-1:0] eh,
                                     logic [wxss_pkg::OFF_W-1:0] eo, logic ee);
    plan_row_t row;
    row = '{default: '0};
    row.val = v;
    row.hash = h;
    row.last = last;
    row.typed = typed;
    row.want.hash = eh;
    row.want.off = eo;
    row.want.run_end = ee;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void plan_kmer(logic [wxss_pkg::VAL_W-1:0] v,
                                    logic [wxss_pkg::HASH_W-1:0] h, bit last);
    plan_known(v, h, last, 1'b0, '0, '0, 1'b0);
  endfunction

  function automatic void plan_reg(logic [wxss_pkg::CFG_IDX_W-1:0] idx,
                                   logic [wxss_pkg::CFG_W-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    plan.insert(plan.size(), row);
  endfunction

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0: w = 64'($urandom_range(15));
      1: w = ~64'($urandom_range(15));
      2: w = $urandom_range(1) ? '1 : '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_kmer(logic [wxss_pkg::VAL_W-1:0] v, logic [wxss_pkg::HASH_W-1:0] h,
                           bit last, bit typed, strobe_t want);
    strobe_t r;
    bit      got;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_kmer_value <= v;
    in_kmer_hash <= h;
    in_is_last <= last;
    do @(posedge clk); while (!in_ready);
    got = take_kmer(v, h, last, r);
    if (typed) strobes_due.insert(strobes_due.size(), want);
    else if (got) strobes_due.insert(strobes_due.size(), r);
  endtask

  // hold off until every strobe is out and any flush has had time to finish
  task automatic settle();
    int unsigned lo;
    int unsigned hi;
    in_valid <= 1'b0;
    while (strobes_due.size() != 0) @(posedge clk);
    lo = near_off();
    hi = far_off(lo);
    repeat (64 * (hi - lo + 6) + 20) @(posedge clk);
  endtask

  task automatic write_reg(logic [wxss_pkg::CFG_IDX_W-1:0] idx,
                           logic [wxss_pkg::CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    set_reg(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin : watch
    strobe_t w;
    if (rst_n && out_valid && out_ready) begin
      if (strobes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got hash %h offset %0d run_end %b",
                 $time, out_strobe_hash, out_partner_offset, out_run_end);
      end else begin
        w = strobes_due.pop_front();
        if (out_strobe_hash !== w.hash) begin
          errors++;
          $display("%0t: strobe_hash expected %h got %h", $time, w.hash, out_strobe_hash);
        end
        if (out_partner_offset !== w.off) begin
          errors++;
          $display("%0t: partner_offset expected %0d got %0d", $time, w.off,
                   out_partner_offset);
        end
        if (out_run_end !== w.run_end) begin
          errors++;
          $display("%0t: run_end expected %b got %b", $time, w.run_end, out_run_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    strobe_t                    none;
    int unsigned                left_in_seq;
    int unsigned                lo;
    int unsigned                hi;
    logic [wxss_pkg::CFG_W-1:0] lo_w;
    logic [wxss_pkg::CFG_W-1:0] hi_w;
    logic                       pick_w;
    none = '0;
    left_in_seq = 0;

    // defaults: window 1..8, least XOR
    plan_kmer(64'h0, 64'h0, 1'b1);
    plan_kmer(64'h0, 64'h1, 1'b0);
    plan_kmer(64'h5, 64'h7, 1'b0);
    plan_known(64'h0, 64'h2, 1'b1, 1'b1, 64'h0, 6'd2, 1'b1);
    plan_kmer('1, '1, 1'b0);
    plan_kmer('1, '0, 1'b0);
    plan_known('0, 64'h1234, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 6'd1, 1'b1);
    // greatest XOR, then a tie that keeps the nearer partner
    plan_reg(wxss_pkg::CFG_PICK_MAX, 6'h3F);
    plan_kmer(64'h0, 64'h0, 1'b0);
    plan_kmer(64'h0, 64'h9, 1'b0);
    plan_known('1, 64'h1, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 1'b1);
    plan_kmer(64'h0, 64'h3, 1'b0);
    plan_kmer(64'h7, 64'h1, 1'b0);
    plan_known(64'h7, 64'h8, 1'b1, 1'b1, 64'd5, 6'd1, 1'b1);
    plan_reg(CFG_UNUSED, 6'h2A);
    // equal offsets: the anchor at N-1-min is never emitted
    plan_reg(wxss_pkg::CFG_PICK_MAX, 6'h3E);
    plan_reg(wxss_pkg::CFG_WINDOW_MIN, 6'd2);
    plan_reg(wxss_pkg::CFG_WINDOW_MAX, 6'd2);
    plan_kmer(64'hA5A5_A5A5_A5A5_A5A5, 64'd10, 1'b0);
    plan_kmer(64'h5A5A_5A5A_5A5A_5A5A, 64'd20, 1'b0);
    plan_kmer(64'hA5A5_A5A5_0000_0000, 64'd30, 1'b0);
    plan_kmer(64'h0123_4567_89AB_CDEF, 64'd40, 1'b1);
    // min clamped up to 1; flush leaves a strobe for the next sequence
    plan_reg(wxss_pkg::CFG_WINDOW_MIN, 6'd0);
    plan_reg(wxss_pkg::CFG_WINDOW_MAX, 6'd3);
    plan_kmer(64'h11, 64'hFFFF_0000_FFFF_0000, 1'b0);
    plan_kmer(64'h22, 64'h8000_0000_0000_0001, 1'b0);
    plan_kmer(64'h13, 64'h3, 1'b0);
    plan_kmer(64'h30, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    plan_kmer(64'h10, 64'h55, 1'b1);
    plan_kmer(64'hDEAD_BEEF_0000_0001, 64'h66, 1'b1);
    // settings changed inside a sequence
    plan_kmer(64'h8, 64'h100, 1'b0);
    plan_kmer(64'h9, 64'h200, 1'b0);
    plan_reg(wxss_pkg::CFG_WINDOW_MAX, 6'd1);
    plan_kmer(64'hC, 64'h300, 1'b0);
    plan_kmer(64'h8, 64'h400, 1'b1);
    plan_reg(wxss_pkg::CFG_WINDOW_MAX, 6'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_kmer(plan[i].val, plan[i].hash, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lo_w = 6'd63; hi_w = 6'd63; pick_w = 1'b0; end
        1: begin lo_w = 6'd0;  hi_w = 6'd0;  pick_w = 1'b1; end
        2: begin lo_w = 6'd1;  hi_w = 6'd63; pick_w = 1'b1; end
        3: begin lo_w = 6'd62; hi_w = 6'd5;  pick_w = 1'b0; end
        4: begin lo_w = 6'd1;  hi_w = 6'd63; pick_w = 1'b0; end
        default: begin
          lo_w = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
          hi_w = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                         : 6'(lo_w + $urandom_range(20));
          pick_w = 1'($urandom_range(1));
        end
      endcase
      settle();
      calm = (p == 6);
      write_reg(wxss_pkg::CFG_WINDOW_MIN, lo_w);
      write_reg(wxss_pkg::CFG_WINDOW_MAX, hi_w);
      write_reg(wxss_pkg::CFG_PICK_MAX, {5'($urandom_range(31)), pick_w});
      lo = near_off();
      hi = far_off(lo);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (left_in_seq == 0) begin
          case ($urandom_range(9))
            0: left_in_seq = $urandom_range(1, 3);
            1: left_in_seq = $urandom_range(1, 100);
            default: left_in_seq = $urandom_range(lo + 2, hi + lo + 20);
          endcase
        end
        send_kmer(rand_word(), rand_word(), left_in_seq == 1, 1'b0, none);
        left_in_seq--;
      end
    end

    calm = 1'b0;
    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/wxss_pkg.sv
hdl/wxss_ring.sv
hdl/wxss_score.sv
hdl/wxss_rq.sv
hdl/windowed_xor_strobe_selector.sv
tb/tb_windowed_xor_strobe_selector.sv
